>>> design/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg: shared types and constants of the text console writer
// Screen geometry, field widths, op codes, register indexes and the
// controller state type.
// ----------------------------------------------------------------------------
package tcw_pkg;

  // Screen geometry
  localparam int ROWS    = 25;
  localparam int COLUMNS = 80;
  localparam int CELLS   = ROWS * COLUMNS;

  // Derived widths
  localparam int ADDR_W = $clog2(CELLS);
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_W  = $clog2(COLUMNS + 1);

  // Field widths
  localparam int OP_W    = 2;
  localparam int CHAR_W  = 8;
  localparam int IDX_W   = 11;
  localparam int OFFS_W  = 11;
  localparam int CELL_W  = 16;
  localparam int COLOR_W = 4;

  // Configuration port widths
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // Characters
  localparam logic [CHAR_W-1:0] CH_LF      = 8'd10;
  localparam logic [CHAR_W-1:0] CH_CR      = 8'd13;
  localparam logic [CHAR_W-1:0] BLANK_CHAR = 8'h20;

  // Op codes
  localparam logic [OP_W-1:0] OP_PRINT = 2'd0;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
  localparam logic [OP_W-1:0] OP_READ  = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FG = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BG = 2'd1;

  // Reset colors
  localparam logic [COLOR_W-1:0] FG_RESET = 4'd7;
  localparam logic [COLOR_W-1:0] BG_RESET = 4'd0;

  // Controller states
  typedef enum logic [2:0] {
    ST_INIT,    // clearing pass after reset
    ST_IDLE,    // waiting for an item
    ST_COPY,    // scroll: move rows up one
    ST_FILL,    // write blank cells up to the last cell
    ST_PUT,     // write one character cell
    ST_RDWAIT,  // read data coming back
    ST_DONE     // result ready to be loaded
  } state_t;

  // Cell word from attribute nibbles and character
  function automatic logic [CELL_W-1:0] make_cell(input logic [COLOR_W-1:0] fg,
                                                  input logic [COLOR_W-1:0] bg,
                                                  input logic [CHAR_W-1:0] ch);
    return {bg, fg, ch};
  endfunction

  // Linear cell position of row and column
  function automatic logic [31:0] cell_pos(input logic [ROW_W-1:0] row,
                                           input logic [COL_W-1:0] col);
    return 32'(row) * 32'(COLUMNS) + 32'(col);
  endfunction

endpackage

>>> design/tcw_if.sv
// ----------------------------------------------------------------------------
// tcw_if: handshake channels of the text console writer
// Input items, result items and configuration writes, each with valid
// and ready and a source and a sink modport.
// ----------------------------------------------------------------------------
interface tcw_in_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [CHAR_W-1:0] char_code;
  logic [IDX_W-1:0]  cell_index;

  modport source (output valid, opcode, char_code, cell_index, input ready);
  modport sink   (input valid, opcode, char_code, cell_index, output ready);
endinterface

interface tcw_out_if import tcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OFFS_W-1:0] cursor_offset;
  logic [CELL_W-1:0] cell_data;

  modport source (output valid, cursor_offset, cell_data, input ready);
  modport sink   (input valid, cursor_offset, cell_data, output ready);
endinterface

interface tcw_cfg_if import tcw_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> design/text_console_writer_top.sv
// ----------------------------------------------------------------------------
// text_console_writer_top: text-mode console engine
// Screen cells live in one synchronous RAM; a small controller prints,
// scrolls, clears and reads cells through it.
// ----------------------------------------------------------------------------
//  channel   dir  handshake       payload
//  in_ch     in   valid/ready     opcode, char_code, cell_index
//  out_ch    out  valid/ready     cursor_offset, cell_data
//  cfg_ch    in   valid/ready     index, data (always ready)
//
//  Print: accept, cell write (ST_PUT), result load (ST_DONE); newline or carriage
//  return skips the cell write. Read: registered RAM read, then result load.
//  Clear: blank fill of all CELLS cells, then result load. A scroll adds a copy
//  pass that moves the rows up and a blank fill of the last row, at most one RAM
//  write per cycle, for a newline on the last row or a character that wraps there.
//  After reset a clearing pass zeroes every RAM cell while
//  in_ch.ready stays low; configuration writes are taken throughout.
//  A result waiting on out_ch does not block the next item; only the
//  next result waits for it.
// ----------------------------------------------------------------------------
module text_console_writer_top
  import tcw_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  tcw_in_if.sink    in_ch,
  tcw_out_if.source out_ch,
  tcw_cfg_if.sink   cfg_ch
);

  // Screen RAM
  logic [CELL_W-1:0] mem [CELLS];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_wa;
  logic [CELL_W-1:0] mem_wd;
  logic [ADDR_W-1:0] mem_ra;
  logic [CELL_W-1:0] rdata_r;

  // Control registers
  state_t            state_r, state_nxt;
  logic [ADDR_W-1:0] ptr_r, ptr_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic              pend_r, pend_nxt;
  logic              cp_we_r, cp_we_nxt;
  logic [ADDR_W-1:0] cp_wa_r, cp_wa_nxt;
  logic [CHAR_W-1:0] ch_r, ch_nxt;
  logic [CELL_W-1:0] data_r, data_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [COLOR_W-1:0] fg_r, bg_r;

  // Result register
  logic              out_valid_r;
  logic [OFFS_W-1:0] out_offs_r;
  logic [CELL_W-1:0] out_data_r;

  logic in_fire;
  logic idx_ok;
  logic load_out;
  logic [ADDR_W-1:0] cur_addr;
  logic [CELL_W-1:0] blank_cell;

  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [ADDR_W-1:0] COPY_END  = ADDR_W'(CELLS - COLUMNS);
  localparam logic [ADDR_W-1:0] COL_STEP  = ADDR_W'(COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(ROWS - 1);
  localparam logic [COL_W-1:0]  COL_FULL  = COL_W'(COLUMNS);

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign idx_ok      = 32'(in_ch.cell_index) < 32'(CELLS);
  assign load_out    = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);
  assign cur_addr    = ADDR_W'(cell_pos(row_r, col_r));
  assign blank_cell  = make_cell(fg_r, bg_r, BLANK_CHAR);

  // Configuration registers
  assign cfg_ch.ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fg_r <= FG_RESET;
      bg_r <= BG_RESET;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_FG:  fg_r <= cfg_ch.data[COLOR_W-1:0];
        REG_BG:  bg_r <= cfg_ch.data[COLOR_W-1:0];
        default: ;
      endcase
    end
  end

  // Next state and register updates
  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    row_nxt   = row_r;
    col_nxt   = col_r;
    pend_nxt  = pend_r;
    cp_we_nxt = 1'b0;
    cp_wa_nxt = cp_wa_r;
    ch_nxt    = ch_r;
    data_nxt  = data_r;
    rd_ok_nxt = rd_ok_r;
    case (state_r)
      ST_INIT: begin
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST_CELL) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          data_nxt = '0;
          ch_nxt   = in_ch.char_code;
          ptr_nxt  = '0;
          pend_nxt = 1'b0;
          case (in_ch.opcode)
            OP_PRINT: begin
              if (in_ch.char_code == CH_LF || in_ch.char_code == CH_CR ||
                  col_r >= COL_FULL) begin
                // move to the next row, scrolling at the bottom
                col_nxt  = '0;
                pend_nxt = !(in_ch.char_code == CH_LF || in_ch.char_code == CH_CR);
                if (row_r == LAST_ROW) begin
                  state_nxt = ST_COPY;
                end else begin
                  row_nxt   = row_r + 1'b1;
                  state_nxt = pend_nxt ? ST_PUT : ST_DONE;
                end
              end else begin
                state_nxt = ST_PUT;
              end
            end
            OP_CLEAR: begin
              row_nxt   = '0;
              col_nxt   = '0;
              state_nxt = ST_FILL;
            end
            OP_READ: begin
              rd_ok_nxt = idx_ok;
              state_nxt = ST_RDWAIT;
            end
            default: state_nxt = ST_DONE;
          endcase
        end
      end
      ST_COPY: begin
        // read runs one cell ahead of the write back
        if (ptr_r == COPY_END) begin
          state_nxt = ST_FILL;
        end else begin
          cp_we_nxt = 1'b1;
          cp_wa_nxt = ptr_r;
          ptr_nxt   = ptr_r + 1'b1;
        end
      end
      ST_FILL: begin
        ptr_nxt = ptr_r + 1'b1;
        if (ptr_r == LAST_CELL) begin
          state_nxt = pend_r ? ST_PUT : ST_DONE;
        end
      end
      ST_PUT: begin
        col_nxt   = col_r + 1'b1;
        pend_nxt  = 1'b0;
        state_nxt = ST_DONE;
      end
      ST_RDWAIT: begin
        data_nxt  = rd_ok_r ? rdata_r : '0;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // RAM port control
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ptr_r;
    mem_wd = blank_cell;
    mem_ra = '0;
    case (state_r)
      ST_INIT: begin
        mem_we = 1'b1;
        mem_wd = '0;
      end
      ST_IDLE: begin
        if (idx_ok) begin
          mem_ra = ADDR_W'(in_ch.cell_index);
        end
      end
      ST_COPY: begin
        mem_we = cp_we_r;
        mem_wa = cp_wa_r;
        mem_wd = rdata_r;
        if (ptr_r != COPY_END) begin
          mem_ra = ptr_r + COL_STEP;
        end
      end
      ST_FILL: begin
        mem_we = 1'b1;
      end
      ST_PUT: begin
        mem_we = 1'b1;
        mem_wa = cur_addr;
        mem_wd = make_cell(fg_r, bg_r, ch_r);
      end
      default: ;
    endcase
  end

  // Screen RAM, one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rdata_r <= mem[mem_ra];
  end

  // Controller registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      ptr_r   <= '0;
      row_r   <= '0;
      col_r   <= '0;
      pend_r  <= 1'b0;
      cp_we_r <= 1'b0;
      rd_ok_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ptr_r   <= ptr_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      pend_r  <= pend_nxt;
      cp_we_r <= cp_we_nxt;
      rd_ok_r <= rd_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cp_wa_r <= cp_wa_nxt;
    ch_r    <= ch_nxt;
    data_r  <= data_nxt;
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_offs_r <= OFFS_W'(cell_pos(row_r, col_r));
      out_data_r <= data_r;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.cursor_offset = out_offs_r;
  assign out_ch.cell_data     = out_data_r;

  // Checks
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (32'(row_r) < 32'(ROWS)) && (col_r <= COL_FULL))
    else $error("cursor out of range");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE || state_r == ST_DONE || state_r == ST_RDWAIT) |-> !mem_we)
    else $error("RAM write outside an update sequence");

  a_item_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> state_r != ST_IDLE)
    else $error("accepted item did not start work");

  a_copy_behind_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COPY && cp_we_r) |-> (cp_wa_r + 1'b1 == ptr_r))
    else $error("scroll write back out of step with read");

  a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> $past(state_r == ST_DONE))
    else $error("result loaded outside the done state");

endmodule
